@@ rtl/firc_pkg.sv @@
package firc_pkg;

    // Filter length and derived widths
    localparam int TAPS      = 64;
    localparam int SMP_W     = 16;
    localparam int IDX_W     = 6;
    localparam int FRAC_BITS = 15;
    localparam int PROD_W    = 2 * SMP_W;
    localparam int ACC_W     = PROD_W + ((TAPS > 1) ? $clog2(TAPS) : 1);
    localparam int CNT_W     = (TAPS > 1) ? $clog2(TAPS) : 1;

    // Item opcodes
    localparam logic OP_COEFF  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef logic signed [SMP_W-1:0]  t_smp;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACC_W-1:0]  t_acc;

    // Per-cell controls
    typedef struct packed {
        logic shift_smp;  // take sample from left neighbor
        logic shift_cof;  // take coefficient from left neighbor
        logic cof_we;     // load coefficient from the write word
    } t_cell_ctrl;

    // MAC controls
    typedef struct packed {
        logic clr;        // clear accumulator
        logic mul_en;     // multiply head cell pair
    } t_mac_ctrl;

endpackage

@@ rtl/firc_if.sv @@
// Input channel: coefficient write or sample word
interface firc_in_if;
    logic                            valid;
    logic                            ready;
    logic                            op;
    logic [firc_pkg::IDX_W-1:0]      tap_index;
    logic signed [firc_pkg::SMP_W-1:0] coeff_value;
    logic signed [firc_pkg::SMP_W-1:0] sample_in;

    modport source (output valid, op, tap_index, coeff_value, sample_in, input ready);
    modport sink   (input valid, op, tap_index, coeff_value, sample_in, output ready);
endinterface

// Output channel: filtered sample word
interface firc_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [firc_pkg::SMP_W-1:0] sample_out;
    logic                            saturated;

    modport source (output valid, sample_out, saturated, input ready);
    modport sink   (input valid, sample_out, saturated, output ready);
endinterface

@@ rtl/firc_cell.sv @@
// One tap of the ring: holds a sample and a coefficient
module firc_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  firc_pkg::t_cell_ctrl i_ctrl,
    input  firc_pkg::t_smp       i_smp,
    input  firc_pkg::t_smp       i_cof,
    input  firc_pkg::t_smp       i_cof_wr,
    output firc_pkg::t_smp       o_smp,
    output firc_pkg::t_smp       o_cof
);

    firc_pkg::t_smp r_smp;
    firc_pkg::t_smp r_cof;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smp <= '0;
            r_cof <= '0;
        end else begin
            if (i_ctrl.shift_smp) begin
                r_smp <= i_smp;
            end
            if (i_ctrl.shift_cof) begin
                r_cof <= i_cof;
            end else if (i_ctrl.cof_we) begin
                r_cof <= i_cof_wr;
            end
        end
    end

    assign o_smp = r_smp;
    assign o_cof = r_cof;

endmodule

@@ rtl/firc_mac.sv @@
// Shared multiply-accumulate with round-toward-zero and saturation
module firc_mac (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  firc_pkg::t_mac_ctrl i_ctrl,
    input  firc_pkg::t_smp      i_cof,
    input  firc_pkg::t_smp      i_smp,
    output firc_pkg::t_smp      o_y,
    output logic                o_sat
);

    localparam firc_pkg::t_acc Y_MAX = firc_pkg::ACC_W'(32767);
    localparam firc_pkg::t_acc Y_MIN = ~Y_MAX;
    localparam firc_pkg::t_acc BIAS  = firc_pkg::ACC_W'((1 << firc_pkg::FRAC_BITS) - 1);

    firc_pkg::t_prod r_prod;
    logic            r_prod_vld;
    firc_pkg::t_acc  r_acc;

    firc_pkg::t_acc  w_sum;
    firc_pkg::t_acc  w_q;

    always_ff @(posedge i_clk) begin
        r_prod <= i_cof * i_smp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            r_acc      <= '0;
        end else begin
            r_prod_vld <= i_ctrl.mul_en;
            if (i_ctrl.clr) begin
                r_acc <= '0;
            end else if (r_prod_vld) begin
                r_acc <= r_acc + firc_pkg::ACC_W'(r_prod);
            end
        end
    end

    // negative sums get a bias so the arithmetic shift truncates toward zero
    always_comb begin
        w_sum = r_acc + (r_acc[firc_pkg::ACC_W-1] ? BIAS : '0);
        w_q   = w_sum >>> firc_pkg::FRAC_BITS;
        if (w_q > Y_MAX) begin
            o_y   = Y_MAX[firc_pkg::SMP_W-1:0];
            o_sat = 1'b1;
        end else if (w_q < Y_MIN) begin
            o_y   = Y_MIN[firc_pkg::SMP_W-1:0];
            o_sat = 1'b1;
        end else begin
            o_y   = w_q[firc_pkg::SMP_W-1:0];
            o_sat = 1'b0;
        end
    end

endmodule

@@ rtl/fir_filter_circular_unit.sv @@
// Channel  Dir  Words                                   Payload
// i_in     in   coefficient write (op 0), sample (op 1)  op, tap_index, coeff_value, sample_in
// o_out    out  one filtered sample per sample word      sample_out, saturated
//
// A coefficient word is written into its cell on acceptance. A sample word
// passes from acceptance to the output register through a shift into the
// ring, a rotation of all TAPS taps past the single multiplier, a drain step
// and a finish step. The shared multiply-accumulate sets the rate.
// i_in is ready only while idle; a finished word waits in the output register
// and the finish step stalls until that register is free.
// Reset (synchronous, active low) clears all taps, coefficients and control.
module fir_filter_circular_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    firc_in_if.sink     i_in,
    firc_out_if.source  o_out
);

    localparam int TAPS = firc_pkg::TAPS;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [firc_pkg::CNT_W-1:0] r_cnt, n_cnt;

    logic            r_out_valid;
    firc_pkg::t_smp  r_out_y;
    logic            r_out_sat;

    logic w_accept, w_cof_wr, w_smp_ins, w_rotate, w_out_free;

    firc_pkg::t_cell_ctrl w_cell_ctrl [TAPS];
    firc_pkg::t_smp       w_smp       [TAPS];
    firc_pkg::t_smp       w_cof       [TAPS];
    firc_pkg::t_mac_ctrl  w_mac_ctrl;
    firc_pkg::t_smp       w_y;
    logic                 w_sat;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_cof_wr   = w_accept && (i_in.op == firc_pkg::OP_COEFF);
    assign w_smp_ins  = w_accept && (i_in.op == firc_pkg::OP_SAMPLE);
    assign w_rotate   = (r_state == S_RUN);
    assign w_out_free = !r_out_valid || o_out.ready;

    // Ring of cells. Cell k holds the sample k steps old and coefficient k
    // when idle; during a run the whole ring turns once past cell 0.
    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        firc_pkg::t_smp w_smp_in;
        firc_pkg::t_smp w_cof_in;

        if (k == 0) begin : g_head
            assign w_smp_in = w_smp_ins ? i_in.sample_in : w_smp[TAPS-1];
            assign w_cof_in = w_cof[TAPS-1];
        end else begin : g_body
            assign w_smp_in = w_smp[k-1];
            assign w_cof_in = w_cof[k-1];
        end

        // out-of-range indexes match no cell and are dropped
        assign w_cell_ctrl[k].shift_smp = w_smp_ins || w_rotate;
        assign w_cell_ctrl[k].shift_cof = w_rotate;
        assign w_cell_ctrl[k].cof_we    = w_cof_wr && (32'(i_in.tap_index) == k);

        firc_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (w_cell_ctrl[k]),
            .i_smp    (w_smp_in),
            .i_cof    (w_cof_in),
            .i_cof_wr (i_in.coeff_value),
            .o_smp    (w_smp[k]),
            .o_cof    (w_cof[k])
        );
    end

    // MAC reads the head cell each rotation cycle
    assign w_mac_ctrl.clr    = w_smp_ins;
    assign w_mac_ctrl.mul_en = w_rotate;

    firc_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_mac_ctrl),
        .i_cof   (w_cof[0]),
        .i_smp   (w_smp[0]),
        .o_y     (w_y),
        .o_sat   (w_sat)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (w_smp_ins) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == firc_pkg::CNT_W'(TAPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_FIN) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN) && w_out_free) begin
            r_out_y   <= w_y;
            r_out_sat <= w_sat;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_y;
    assign o_out.saturated  = r_out_sat;

    // Assertions
    a_run_length : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_smp_ins |-> ##(TAPS + 2) (r_state == S_FIN))
        else $error("sample run did not reach finish on time");

    a_fin_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) && !w_out_free |=> (r_state == S_FIN))
        else $error("result left finish while output register busy");

    a_cnt_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_RUN) |-> (r_cnt == '0))
        else $error("tap counter not cleared outside run");

endmodule

@@ bench/tb_top.sv @@
module tb_top;

    // Idle cycles with no word moving on either channel before giving up.
    // Slowest correct stretch: the long sink hold-off plus one full MAC pass.
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned CHOKE_CYCLES = 400;
    // Idling stops once this few input words remain.
    localparam int unsigned CALM_TAIL = 40;
    localparam int unsigned RANDOM_WORDS = 500;
    // Sets the length of the drain wait at the end.
    localparam int unsigned PASS_CYCLES = firc_pkg::TAPS + 3;

    // One input word: coefficient write or sample
    typedef struct {
        logic                           op;
        logic [firc_pkg::IDX_W-1:0]     tap;
        firc_pkg::t_smp                 coef;
        firc_pkg::t_smp                 smp;
    } t_fir_word;

    // One filtered output word
    typedef struct {
        firc_pkg::t_smp y;
        logic           sat;
    } t_filt_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    firc_in_if  in_ch ();
    firc_out_if out_ch ();

    fir_filter_circular_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // Stimulus and scoreboard state
    t_fir_word   pending_words[$];
    t_filt_res   expected_out[$];
    int unsigned total_words = 0;
    int unsigned words_in = 0;
    int unsigned words_out = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned idle_cycles = 0;
    int unsigned src_gap = 0;
    int unsigned sink_wait = 0;
    logic        in_fire = 1'b0;
    logic        choke = 1'b0;

    // Filter model state: coefficient table, sample history, next slot
    firc_pkg::t_smp coef_tab[firc_pkg::TAPS];
    firc_pkg::t_smp history[firc_pkg::TAPS];
    int unsigned    head = 0;

    // Coefficient write; every 6-bit index is a valid tap at 64 taps
    function automatic void load_coeff(input logic [firc_pkg::IDX_W-1:0] tap,
                                       input firc_pkg::t_smp val);
        if (int'(tap) < firc_pkg::TAPS)
            coef_tab[tap] = val;
    endfunction

    // Store the sample as newest, run the dot product with h[0] on the
    // newest sample, then scale by 2^-15 toward zero and clamp.
    function automatic t_filt_res filter_sample(input firc_pkg::t_smp s);
        t_filt_res r;
        longint    acc;
        longint    q;
        int        k;
        history[head] = s;
        acc = 0;
        for (k = 0; k < firc_pkg::TAPS; k++)
            acc += longint'(coef_tab[k]) *
                   longint'(history[(head + firc_pkg::TAPS - k) % firc_pkg::TAPS]);
        head = (head + 1) % firc_pkg::TAPS;
        r.sat = 1'b0;
        if (acc < 0) begin
            q = (-acc) >> firc_pkg::FRAC_BITS;
            if (q > 32768) begin
                r.y   = -16'sd32768;
                r.sat = 1'b1;
            end else begin
                r.y = firc_pkg::t_smp'(-q);
            end
        end else begin
            q = acc >> firc_pkg::FRAC_BITS;
            if (q > 32767) begin
                r.y   = 16'sd32767;
                r.sat = 1'b1;
            end else begin
                r.y = firc_pkg::t_smp'(q);
            end
        end
        return r;
    endfunction

    // Don't-care fields carry random junk so the block must ignore them
    function automatic void add_coef(input logic [firc_pkg::IDX_W-1:0] tap,
                                     input firc_pkg::t_smp val);
        t_fir_word w;
        w.op   = firc_pkg::OP_COEFF;
        w.tap  = tap;
        w.coef = val;
        w.smp  = firc_pkg::t_smp'($urandom);
        pending_words.push_back(w);
    endfunction

    function automatic void add_sample(input firc_pkg::t_smp val);
        t_fir_word w;
        w.op   = firc_pkg::OP_SAMPLE;
        w.tap  = firc_pkg::IDX_W'($urandom);
        w.coef = firc_pkg::t_smp'($urandom);
        w.smp  = val;
        pending_words.push_back(w);
    endfunction

    // Random sample: mostly full range, sometimes pinned to a rail
    function automatic firc_pkg::t_smp rand_sample();
        case ($urandom_range(0, 7))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            default: return firc_pkg::t_smp'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        int unsigned shift;
        int unsigned n;
        int unsigned k;
        for (k = 0; k < firc_pkg::TAPS; k++) begin
            coef_tab[k] = '0;
            history[k]  = '0;
        end
        in_ch.valid       = 1'b0;
        in_ch.op          = firc_pkg::OP_COEFF;
        in_ch.tap_index   = '0;
        in_ch.coeff_value = '0;
        in_ch.sample_in   = '0;
        out_ch.ready      = 1'b0;

        // Directed: all-zero taps, truncation toward zero on tiny sums,
        // positive and negative clamping, edge taps 0/1/63, bit patterns.
        add_sample(16'sd32767);
        add_coef(6'd0, 16'sd1);
        add_sample(-16'sd1);
        add_sample(16'sd1);
        add_coef(6'd0, -16'sd32768);
        add_sample(-16'sd32768);
        add_sample(16'sd32767);
        add_coef(6'd63, 16'sd32767);
        add_coef(6'd1, -16'sd32768);
        add_sample(-16'sd32768);
        add_coef(6'd0, 16'sd32767);
        add_coef(6'd1, 16'sd32767);
        add_coef(6'd63, 16'sd0);
        add_sample(-16'sd32768);
        add_sample(-16'sd32768);
        add_coef(6'd42, 16'sh5555);
        add_coef(6'd21, 16'shAAAA);
        add_sample(16'sh5555);
        add_sample(16'shAAAA);
        add_sample(16'sd0);

        // Random: blocks of coefficient loads at a random scale, then a
        // run of samples with the odd coefficient update mixed in.
        // Large shifts keep sums in range, small ones drive saturation.
        n = pending_words.size() + RANDOM_WORDS;
        while (pending_words.size() < n) begin
            shift = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            repeat ($urandom_range(1, 16))
                add_coef(firc_pkg::IDX_W'($urandom), firc_pkg::t_smp'($urandom) >>> shift);
            repeat ($urandom_range(5, 30)) begin
                if ($urandom_range(0, 9) == 0)
                    add_coef(firc_pkg::IDX_W'($urandom),
                             firc_pkg::t_smp'($urandom) >>> shift);
                else
                    add_sample(rand_sample());
            end
        end
        total_words = pending_words.size();

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // All words in and all results back, then let stray words show up
        wait (words_in == total_words && expected_out.size() == 0);
        repeat (2 * PASS_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Driver: new word at the falling edge once the previous one was taken.
    // Held words stay put while ready is low.
    always @(negedge i_clk) begin : drive
        t_fir_word w;
        if (i_rst_n && !(in_ch.valid && !in_fire)) begin
            if (src_gap > 0) begin
                src_gap--;
                in_ch.valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                w = pending_words.pop_front();
                in_ch.op          <= w.op;
                in_ch.tap_index   <= w.tap;
                in_ch.coeff_value <= w.coef;
                in_ch.sample_in   <= w.smp;
                in_ch.valid       <= 1'b1;
                if (pending_words.size() >= CALM_TAIL && $urandom_range(0, 6) == 0)
                    src_gap = $urandom_range(1, 15);
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Sink side ready: random stall bursts, plus the long choke
    always @(negedge i_clk) begin
        if (choke) begin
            out_ch.ready <= 1'b0;
        end else if (sink_wait > 0) begin
            sink_wait--;
            out_ch.ready <= 1'b0;
        end else if (pending_words.size() >= CALM_TAIL && $urandom_range(0, 5) == 0) begin
            sink_wait = $urandom_range(0, 14);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Long hold-off on the sink once traffic is flowing: the block fills its
    // output register and its MAC, then must drop input ready.
    initial begin
        wait (words_out >= 20);
        @(negedge i_clk);
        choke <= 1'b1;
        repeat (CHOKE_CYCLES) @(negedge i_clk);
        choke <= 1'b0;
    end

    // Monitor: check outputs against the oldest expectation first, then
    // run accepted input words through the model.
    always @(posedge i_clk) begin : watch
        t_filt_res e;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                words_out++;
                if (expected_out.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: unexpected output word, expected none, actual %0d sat %0b",
                             $time, out_ch.sample_out, out_ch.saturated);
                end else begin
                    e = expected_out.pop_front();
                    if (out_ch.sample_out !== e.y) begin
                        mismatch_cnt++;
                        $display("%0t: sample_out mismatch, expected %0d actual %0d",
                                 $time, e.y, out_ch.sample_out);
                    end
                    if (out_ch.saturated !== e.sat) begin
                        mismatch_cnt++;
                        $display("%0t: saturated mismatch, expected %0b actual %0b",
                                 $time, e.sat, out_ch.saturated);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                words_in++;
                if (in_ch.op == firc_pkg::OP_SAMPLE)
                    expected_out.push_back(filter_sample(in_ch.sample_in));
                else
                    load_coeff(in_ch.tap_index, in_ch.coeff_value);
            end
        end
        in_fire <= in_ch.valid && in_ch.ready;
    end

    // Watchdog: too long with no word moving either way
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

endmodule
